// ===== src/gcts_pkg.sv =====
// ----------------------------------------------------------------------------
// gcts_pkg
// Types, codes and constants shared by the glyph cache tag store.
// ----------------------------------------------------------------------------
package gcts_pkg;

    localparam int TAG_W    = 13;
    localparam int TTL_W    = 2;
    localparam int CODE_W   = 14;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 7;
    localparam int OFFSET_W = 19;
    localparam int BYTES_W  = 8;

    localparam int DOUBLE_BIT = 13;

    typedef logic [TAG_W-1:0]    tag_t;
    typedef logic [TTL_W-1:0]    ttl_t;
    typedef logic [CODE_W-1:0]   code_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [OFFSET_W-1:0] offset_t;
    typedef logic [BYTES_W-1:0]  bytes_t;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_AGE    = 1'b1;

    localparam status_t ST_HIT  = 2'd0;
    localparam status_t ST_FILL = 2'd1;
    localparam status_t ST_FULL = 2'd2;
    localparam status_t ST_AGED = 2'd3;

    localparam ttl_t   TTL_FRESH    = 2'd2;
    localparam bytes_t SINGLE_BYTES = 8'h60;
    localparam bytes_t DOUBLE_BYTES = 8'h80;

    typedef struct packed {
        logic used;
        tag_t tag;
        ttl_t ttl;
    } entry_t;

    typedef struct packed {
        logic hit;
        logic free;
        logic age_wr;
        ttl_t ttl_dec;
    } match_t;

    // tag * 96 = tag * 64 + tag * 32
    function automatic offset_t single_offset(input tag_t t);
        return {t, 6'b0} + {1'b0, t, 5'b0};
    endfunction

    // low 12 tag bits * 128
    function automatic offset_t double_offset(input tag_t t);
        return {t[TAG_W-2:0], 7'b0};
    endfunction

endpackage

// ===== src/gcts_if.sv =====
// ----------------------------------------------------------------------------
// gcts_if
// Valid/ready channels of the glyph cache tag store.
// ----------------------------------------------------------------------------
interface gcts_cfg_if;
    logic valid;
    logic ready;
    logic aging_enable;

    modport source (output valid, output aging_enable, input ready);
    modport sink   (input valid, input aging_enable, output ready);
endinterface

interface gcts_in_if import gcts_pkg::*; ;
    logic  valid;
    logic  ready;
    logic  action;
    code_t codepoint;

    modport source (output valid, output action, output codepoint, input ready);
    modport sink   (input valid, input action, input codepoint, output ready);
endinterface

interface gcts_out_if import gcts_pkg::*; ;
    logic    valid;
    logic    ready;
    status_t status;
    slot_t   slot_index;
    logic    fill_font;
    offset_t fill_offset;
    bytes_t  fill_bytes;

    modport source (output valid, output status, output slot_index, output fill_font,
                    output fill_offset, output fill_bytes, input ready);
    modport sink   (input valid, input status, input slot_index, input fill_font,
                    input fill_offset, input fill_bytes, output ready);
endinterface

// ===== src/glyph_cache_tag_store.sv =====
// Lookup: one slot read per cycle over the slots in order, then one or two slot writes on a
// fill; a full cache answers without writes, and a hit stops the scan early.
// Age tick: reads every slot with aging on, and no slot with aging off.
// One item at a time: the next beat is taken in the cycle after the result beat is accepted.
// Reset: slot valid bits clear at once (all slots free, no tag), aging_enable = 1; no clearing pass.
// ----------------------------------------------------------------------------
// glyph_cache_tag_store
// Glyph cache tag store with TTL aging, sequential slot scan.
// ----------------------------------------------------------------------------
module glyph_cache_tag_store import gcts_pkg::*; #(
    parameter int CACHE_SLOTS = 124
) (
    input  logic        clk,
    input  logic        rst_n,
    gcts_cfg_if.sink    cfg,
    gcts_in_if.sink     req,
    gcts_out_if.source  rsp
);

    localparam int AW = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(CACHE_SLOTS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_WR0  = 3'd2;
    localparam logic [2:0] S_WR1  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic          aging_reg;
    logic          age_op_reg, age_op_next;
    logic          dbl_reg, dbl_next;
    tag_t          tag_reg, tag_next;
    logic          rd_live_reg, rd_live_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic          q_valid_reg, q_valid_next;
    logic [AW-1:0] q_idx_reg, q_idx_next;
    entry_t        prev_reg, prev_next;
    logic          free_found_reg, free_found_next;
    logic [AW-1:0] free_idx_reg, free_idx_next;
    logic [AW-1:0] slot_reg, slot_next;
    status_t       status_reg, status_next;
    logic          font_reg, font_next;
    offset_t       offset_reg, offset_next;
    bytes_t        bytes_reg, bytes_next;

    logic          rd_en;
    entry_t        rd_q;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    match_t        m;
    logic [AW-1:0] scan_idx;

    gcts_slot_ram #(
        .CACHE_SLOTS(CACHE_SLOTS)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_reg),
        .rd_q    (rd_q),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    gcts_match_unit u_match (
        .dbl      (dbl_reg),
        .tag      (tag_reg),
        .has_prev (q_idx_reg != '0),
        .prev     (prev_reg),
        .cur      (rd_q),
        .m        (m)
    );

    assign scan_idx = dbl_reg ? (q_idx_reg - 1'b1) : q_idx_reg;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid       = (state_reg == S_OUT);
    assign rsp.status      = status_reg;
    assign rsp.slot_index  = slot_t'(slot_reg);
    assign rsp.fill_font   = font_reg;
    assign rsp.fill_offset = offset_reg;
    assign rsp.fill_bytes  = bytes_reg;

    always_comb
    begin
        state_next      = state_reg;
        age_op_next     = age_op_reg;
        dbl_next        = dbl_reg;
        tag_next        = tag_reg;
        rd_live_next    = rd_live_reg;
        rd_addr_next    = rd_addr_reg;
        q_valid_next    = 1'b0;
        q_idx_next      = rd_addr_reg;
        prev_next       = prev_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        slot_next       = slot_reg;
        status_next     = status_reg;
        font_next       = font_reg;
        offset_next     = offset_reg;
        bytes_next      = bytes_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = slot_reg;
        wr_data.used    = 1'b1;
        wr_data.tag     = tag_reg;
        wr_data.ttl     = TTL_FRESH;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    age_op_next     = (req.action == ACT_AGE);
                    dbl_next        = req.codepoint[DOUBLE_BIT];
                    tag_next        = req.codepoint[CODE_W-1:1];
                    rd_addr_next    = '0;
                    free_found_next = 1'b0;
                    free_idx_next   = '0;
                    slot_next       = '0;
                    font_next       = 1'b0;
                    offset_next     = '0;
                    bytes_next      = '0;
                    status_next     = ST_AGED;
                    if ((req.action == ACT_AGE) && !aging_reg)
                    begin
                        rd_live_next = 1'b0;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        rd_live_next = 1'b1;
                        state_next   = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (rd_live_reg)
                begin
                    rd_en        = 1'b1;
                    q_valid_next = 1'b1;
                    if (rd_addr_reg == LAST_IDX)
                    begin
                        rd_live_next = 1'b0;
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg + 1'b1;
                    end
                end
                if (q_valid_reg)
                begin
                    prev_next = rd_q;
                    if (age_op_reg)
                    begin
                        if (m.age_wr)
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = q_idx_reg;
                            wr_data.tag = rd_q.tag;
                            wr_data.ttl = m.ttl_dec;
                        end
                        if (q_idx_reg == LAST_IDX)
                        begin
                            status_next = ST_AGED;
                            state_next  = S_OUT;
                        end
                    end
                    else if (m.hit)
                    begin
                        slot_next    = scan_idx;
                        status_next  = ST_HIT;
                        rd_live_next = 1'b0;
                        q_valid_next = 1'b0;
                        state_next   = S_WR0;
                    end
                    else
                    begin
                        if (m.free)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = scan_idx;
                        end
                        if (q_idx_reg == LAST_IDX)
                        begin
                            if (free_found_next)
                            begin
                                slot_next   = free_idx_next;
                                status_next = ST_FILL;
                                font_next   = dbl_reg;
                                offset_next = dbl_reg ? double_offset(tag_reg)
                                                      : single_offset(tag_reg);
                                bytes_next  = dbl_reg ? DOUBLE_BYTES : SINGLE_BYTES;
                                state_next  = S_WR0;
                            end
                            else
                            begin
                                status_next = ST_FULL;
                                state_next  = S_OUT;
                            end
                        end
                    end
                end
            end
            S_WR0:
            begin
                wr_en      = 1'b1;
                state_next = dbl_reg ? S_WR1 : S_OUT;
            end
            S_WR1:
            begin
                wr_en      = 1'b1;
                wr_addr    = slot_reg + 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            aging_reg      <= 1'b1;
            rd_live_reg    <= 1'b0;
            q_valid_reg    <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_live_reg    <= rd_live_next;
            q_valid_reg    <= q_valid_next;
            free_found_reg <= free_found_next;
            if (cfg.valid)
            begin
                aging_reg <= cfg.aging_enable;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        age_op_reg   <= age_op_next;
        dbl_reg      <= dbl_next;
        tag_reg      <= tag_next;
        rd_addr_reg  <= rd_addr_next;
        q_idx_reg    <= q_idx_next;
        prev_reg     <= prev_next;
        free_idx_reg <= free_idx_next;
        slot_reg     <= slot_next;
        status_reg   <= status_next;
        font_reg     <= font_next;
        offset_reg   <= offset_next;
        bytes_reg    <= bytes_next;
    end

endmodule

// ===== src/gcts_slot_ram.sv =====
// ----------------------------------------------------------------------------
// gcts_slot_ram
// Slot tag/TTL memory, one read and one write per cycle, registered read.
// ----------------------------------------------------------------------------
module gcts_slot_ram import gcts_pkg::*; #(
    parameter int CACHE_SLOTS = 124
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   rd_en,
    input  logic [((CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1)-1:0] rd_addr,
    output entry_t rd_q,
    input  logic   wr_en,
    input  logic [((CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1)-1:0] wr_addr,
    input  entry_t wr_data
);

    logic [TAG_W+TTL_W-1:0] mem [CACHE_SLOTS];
    logic [CACHE_SLOTS-1:0] vld_reg;
    logic [TAG_W+TTL_W-1:0] q_reg;
    logic                   used_q_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_data.tag, wr_data.ttl};
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    // never-written slots read as free with a tag that never matches
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            used_q_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                used_q_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_q.used = used_q_reg;
    assign rd_q.tag  = q_reg[TAG_W+TTL_W-1:TTL_W];
    assign rd_q.ttl  = used_q_reg ? q_reg[TTL_W-1:0] : '0;

endmodule

// ===== src/gcts_match_unit.sv =====
// ----------------------------------------------------------------------------
// gcts_match_unit
// Shared per-slot compare: tag match, free test and TTL decrement.
// ----------------------------------------------------------------------------
module gcts_match_unit import gcts_pkg::*; (
    input  logic   dbl,
    input  tag_t   tag,
    input  logic   has_prev,
    input  entry_t prev,
    input  entry_t cur,
    output match_t m
);

    logic cur_eq;
    logic prev_eq;
    logic cur_free;
    logic prev_free;

    assign cur_eq    = cur.used && (cur.tag == tag);
    assign prev_eq   = prev.used && (prev.tag == tag);
    assign cur_free  = (cur.ttl == '0);
    assign prev_free = (prev.ttl == '0);

    // double width tests the pair (prev, cur)
    assign m.hit     = dbl ? (has_prev && prev_eq && cur_eq) : cur_eq;
    assign m.free    = dbl ? (has_prev && prev_free && cur_free) : cur_free;
    assign m.age_wr  = !cur_free;
    assign m.ttl_dec = cur.ttl - 1'b1;

endmodule

// ===== src/gcts_checker.sv =====
// ----------------------------------------------------------------------------
// gcts_checker
// Port-level checks of the glyph cache tag store, bound to the top level.
// ----------------------------------------------------------------------------
module gcts_checker import gcts_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    req_valid,
    input logic    req_ready,
    input logic    rsp_valid,
    input logic    rsp_ready,
    input status_t rsp_status,
    input slot_t   rsp_slot_index,
    input logic    rsp_fill_font,
    input offset_t rsp_fill_offset,
    input bytes_t  rsp_fill_bytes
);

    // stalled result beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_slot_index) && $stable(rsp_fill_offset))
        else $error("result beat changed while stalled");

    // one item in flight: no new beat while a result is pending
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("input ready while result pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("input ready right after accept");

    a_no_fill_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_FILL) |->
            (rsp_fill_bytes == '0) && (rsp_fill_offset == '0) && !rsp_fill_font)
        else $error("fill fields set without a fill");

    a_fill_size: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_FILL) |->
            (rsp_fill_font && (rsp_fill_bytes == DOUBLE_BYTES))
            || (!rsp_fill_font && (rsp_fill_bytes == SINGLE_BYTES)))
        else $error("fill size does not match font table");

endmodule

bind glyph_cache_tag_store gcts_checker u_gcts_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_slot_index  (rsp.slot_index),
    .rsp_fill_font   (rsp.fill_font),
    .rsp_fill_offset (rsp.fill_offset),
    .rsp_fill_bytes  (rsp.fill_bytes)
);
